FILE: rtl/core/top_k_weight_prune_normalize_core_defines.svh
// Assertion macros for the top-k weight pruning core.
// No dependencies; taken in by the top level.
`ifndef TOP_K_WEIGHT_PRUNE_NORMALIZE_CORE_DEFINES_SVH
`define TOP_K_WEIGHT_PRUNE_NORMALIZE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TKWP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tkwp check failed");

// Next-cycle implication, checked outside reset
`define TKWP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tkwp check failed");

`endif

FILE: rtl/core/tkwp_pkg.sv
// Shared constants for the top-k weight pruning core.
// No dependencies.
`default_nettype none
package tkwp_pkg;
    localparam int FIELD_W         = 16;
    localparam int CNT_W           = 4;
    localparam int MAXB_W          = 4;
    localparam int NUM_BONES_DEF   = 8;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;
    localparam int REG_IDX_W       = 1;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MAX_BONES  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_WEIGHT = 1'b1;

    localparam logic [MAXB_W-1:0]  MAX_BONES_RST  = 4'd4;
    localparam logic [FIELD_W-1:0] MIN_WEIGHT_RST = 16'd6;
endpackage
`default_nettype wire

FILE: rtl/core/top_k_weight_prune_normalize_core.sv
// Top-k bone weight pruning and renormalisation core.
// Registers in order: stage A, merge sum and dividend, divider stages, output register.
// Throughput: one vertex per cycle unless the output stalls; one quotient bit a stage.
// Reset (aresetn low, synchronous): pipeline emptied, max_bones=4, min_weight=6.
// Depends on tkwp_pkg, tkwp_rank, tkwp_merge, tkwp_div and the defines header.
`default_nettype none
`include "top_k_weight_prune_normalize_core_defines.svh"
module top_k_weight_prune_normalize_core #(
    parameter int NUM_BONES   = tkwp_pkg::NUM_BONES_DEF,
    parameter int WEIGHT_BITS = tkwp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // weight_0 .. weight_{NUM_BONES-1}, 16 bits each, from the lowest bit up
    input  wire logic [NUM_BONES*tkwp_pkg::FIELD_W-1:0] s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pruned_0 .. pruned_{NUM_BONES-1} (16 bits each), kept_count (4), zero pad
    output logic [((NUM_BONES*tkwp_pkg::FIELD_W+tkwp_pkg::CNT_W+7)/8)*8-1:0] m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tkwp_pkg::APB_AW-1:0]       paddr,
    input  wire logic [tkwp_pkg::APB_DW-1:0]       pwdata,
    output logic [tkwp_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready
);
    import tkwp_pkg::*;

    localparam int NB    = NUM_BONES;
    localparam int WB    = WEIGHT_BITS;
    localparam int SW    = WB + $clog2(NB);
    localparam int RW    = $clog2(NB + 1);
    localparam int OUT_W = ((NB*FIELD_W + CNT_W + 7) / 8) * 8;
    localparam int VD    = WB + 2;

    // configuration registers
    logic [MAXB_W-1:0]    max_bones_reg;
    logic [FIELD_W-1:0]   min_weight_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bones_reg  <= MAX_BONES_RST;
            min_weight_reg <= MIN_WEIGHT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MAX_BONES:  max_bones_reg  <= pwdata[MAXB_W-1:0];
                REG_MIN_WEIGHT: min_weight_reg <= pwdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MAX_BONES:  prdata = APB_DW'(max_bones_reg);
            REG_MIN_WEIGHT: prdata = APB_DW'(min_weight_reg);
            default:        prdata = '0;
        endcase
    end

    // whole pipeline moves when the output register is free or being taken
    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // input weights, masked to WEIGHT_BITS
    logic [NB*WB-1:0] w_in;
    logic [NB-1:0]    keep_in;
    always_comb begin
        for (int i = 0; i < NB; i++) begin
            w_in[i*WB +: WB] = WB'(s_tdata[i*FIELD_W +: FIELD_W]);
        end
    end

    // selection lanes
    for (genvar i = 0; i < NB; i++) begin : g_rank
        tkwp_rank #(.NB(NB), .WB(WB), .LANE(i)) u_rank (
            .w_flat     (w_in),
            .min_weight (min_weight_reg),
            .max_bones  (max_bones_reg),
            .keep       (keep_in[i])
        );
    end

    // stage A registers
    logic [NB*WB-1:0] w_a_reg;
    logic [NB-1:0]    keep_a_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            w_a_reg    <= w_in;
            keep_a_reg <= keep_in;
        end
    end

    // sum and count of kept weights
    logic [SW-1:0] sum_b;
    logic [RW-1:0] cnt_b;
    tkwp_merge #(.NB(NB), .WB(WB)) u_merge (
        .aclk    (aclk),
        .adv     (adv),
        .w_flat  (w_a_reg),
        .keep    (keep_a_reg),
        .sum_reg (sum_b),
        .cnt_reg (cnt_b)
    );

    // divider lanes
    logic [WB-1:0] q [NB];
    for (genvar i = 0; i < NB; i++) begin : g_div
        tkwp_div #(.WB(WB), .SW(SW)) u_div (
            .aclk (aclk),
            .adv  (adv),
            .w    (w_a_reg[i*WB +: WB]),
            .keep (keep_a_reg[i]),
            .s_in (sum_b),
            .q    (q[i])
        );
    end

    // kept count follows the divider stages
    logic [RW-1:0] cnt_pipe_reg [1:WB];
    always_ff @(posedge aclk) begin
        if (adv) begin
            cnt_pipe_reg[1] <= cnt_b;
            for (int k = 2; k <= WB; k++) begin
                cnt_pipe_reg[k] <= cnt_pipe_reg[k-1];
            end
        end
    end

    // valid tracking, one bit per stage
    logic [VD-1:0] v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[VD-2:0], s_tvalid};
        end
    end

    // output register
    logic [OUT_W-1:0] m_tdata_next;
    logic [OUT_W-1:0] m_tdata_reg;
    always_comb begin
        m_tdata_next = '0;
        for (int i = 0; i < NB; i++) begin
            m_tdata_next[i*FIELD_W +: FIELD_W] = FIELD_W'(q[i]);
        end
        m_tdata_next[NB*FIELD_W +: CNT_W] = CNT_W'(cnt_pipe_reg[WB]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= v_reg[VD-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `TKWP_ASSERT_IMP(a_zero_cnt_zero_w, aclk, aresetn,
        m_tvalid && (m_tdata[NB*FIELD_W +: CNT_W] == '0), m_tdata[NB*FIELD_W-1:0] == '0)
    `TKWP_ASSERT_NXT(a_stall_holds, aclk, aresetn, !adv, $stable(v_reg))
    `TKWP_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, v_reg[0])
endmodule
`default_nettype wire

FILE: rtl/core/tkwp_rank.sv
// One selection lane: decides whether its bone is among the kept top-k.
// Depends on tkwp_pkg.
`default_nettype none
module tkwp_rank #(
    parameter int NB   = 8,
    parameter int WB   = 16,
    parameter int LANE = 0
) (
    input  wire logic [NB*WB-1:0]            w_flat,
    input  wire logic [tkwp_pkg::FIELD_W-1:0] min_weight,
    input  wire logic [tkwp_pkg::MAXB_W-1:0]  max_bones,
    output logic                              keep
);
    import tkwp_pkg::*;

    localparam int CW = (WB > FIELD_W) ? WB : FIELD_W;
    localparam int RW = $clog2(NB + 1);
    localparam int KW = RW + MAXB_W;

    logic [CW-1:0] wx [NB];
    logic [NB-1:0] cand;
    logic [NB-1:0] outr;
    logic [RW-1:0] rank;

    // candidates, and which of them outrank this lane (ties to lower index)
    always_comb begin
        rank = '0;
        for (int j = 0; j < NB; j++) begin
            wx[j]   = CW'(w_flat[j*WB +: WB]);
            cand[j] = wx[j] > CW'(min_weight);
        end
        for (int j = 0; j < NB; j++) begin
            outr[j] = (j != LANE) && cand[j] &&
                      ((wx[j] > wx[LANE]) || ((wx[j] == wx[LANE]) && (j < LANE)));
            rank = rank + RW'(outr[j]);
        end
    end

    assign keep = cand[LANE] && (KW'(rank) < KW'(max_bones));
endmodule
`default_nettype wire

FILE: rtl/core/tkwp_merge.sv
// Merging stage: sum and count of the kept weights over all lanes.
// Depends on tkwp_pkg.
`default_nettype none
module tkwp_merge #(
    parameter int NB = 8,
    parameter int WB = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        adv,
    input  wire logic [NB*WB-1:0]            w_flat,
    input  wire logic [NB-1:0]               keep,
    output logic [WB+$clog2(NB)-1:0]         sum_reg,
    output logic [$clog2(NB+1)-1:0]          cnt_reg
);
    import tkwp_pkg::*;

    localparam int SW = WB + $clog2(NB);
    localparam int RW = $clog2(NB + 1);

    logic [SW-1:0] sum_next;
    logic [RW-1:0] cnt_next;

    // adder over the kept lanes
    always_comb begin
        sum_next = '0;
        cnt_next = '0;
        for (int i = 0; i < NB; i++) begin
            if (keep[i]) begin
                sum_next = sum_next + SW'(w_flat[i*WB +: WB]);
            end
            cnt_next = cnt_next + RW'(keep[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/tkwp_div.sv
// Per-lane pipelined restoring divider: floor(w * WMAX / sum), one bit a stage.
// Depends on tkwp_pkg.
`default_nettype none
module tkwp_div #(
    parameter int WB = 16,
    parameter int SW = 19
) (
    input  wire logic          aclk,
    input  wire logic          adv,
    input  wire logic [WB-1:0] w,
    input  wire logic          keep,
    input  wire logic [SW-1:0] s_in,
    output logic [WB-1:0]      q
);
    import tkwp_pkg::*;

    // stage 0 holds the scaled dividend; s_in arrives aligned with it
    logic [SW-1:0] r_reg   [0:WB-1];
    logic [WB-1:0] low_reg [0:WB-1];
    logic [SW-1:0] s_reg   [1:WB-1];
    logic [WB-1:0] q_reg   [1:WB];
    logic          k_reg   [0:WB];

    logic [2*WB-1:0] n;

    // w * WMAX as (w << WB) - w
    assign n = keep ? ({w, {WB{1'b0}}} - {{WB{1'b0}}, w}) : '0;

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg[0]   <= SW'(n[2*WB-1:WB]);
            low_reg[0] <= n[WB-1:0];
            k_reg[0]   <= keep;
        end
    end

    for (genvar k = 0; k < WB; k++) begin : g_stage
        logic [SW-1:0] s_cur;
        logic [WB-1:0] q_cur;
        logic [SW:0]   r2;
        logic [SW:0]   rn;
        logic          ge;

        if (k == 0) begin : g_first
            assign s_cur = s_in;
            assign q_cur = '0;
        end else begin : g_rest
            assign s_cur = s_reg[k];
            assign q_cur = q_reg[k];
        end

        // trial subtract of the shifted remainder
        assign r2 = {r_reg[k], low_reg[k][WB-1]};
        assign ge = r2 >= {1'b0, s_cur};
        assign rn = ge ? (r2 - {1'b0, s_cur}) : r2;

        always_ff @(posedge aclk) begin
            if (adv) begin
                q_reg[k+1] <= {q_cur[WB-2:0], ge};
                k_reg[k+1] <= k_reg[k];
            end
        end

        if (k < WB - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv) begin
                    r_reg[k+1]   <= rn[SW-1:0];
                    low_reg[k+1] <= {low_reg[k][WB-2:0], 1'b0};
                    s_reg[k+1]   <= s_cur;
                end
            end
        end
    end

    // dropped lanes (and empty sums) read as zero
    assign q = q_reg[WB] & {WB{k_reg[WB]}};
endmodule
`default_nettype wire

FILE: test/tb.sv
// Regression bench for the top-k bone weight pruning core: directed vertices, then random.
// Depends on tkwp_pkg and top_k_weight_prune_normalize_core.
`timescale 1ns / 1ps
module tb;
    import tkwp_pkg::*;

    localparam int NB      = NUM_BONES_DEF;
    localparam int IN_W    = NB * FIELD_W;
    localparam int OUT_W   = ((NB * FIELD_W + CNT_W + 7) / 8) * 8;
    localparam int LATENCY = WEIGHT_BITS_DEF + 3;
    localparam logic [FIELD_W-1:0] FULL = 16'hFFFF;

    typedef struct packed {
        logic [CNT_W-1:0]            kept;
        logic [NB-1:0][FIELD_W-1:0]  pruned;
    } vertex_res_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // shadow copy of the registers
    logic [MAXB_W-1:0]     cur_max_bones = MAX_BONES_RST;
    logic [FIELD_W-1:0]    cur_min_weight = MIN_WEIGHT_RST;

    vertex_res_t           expected_q[$];
    int                    errors = 0;

    top_k_weight_prune_normalize_core dut (.*);

    always #10 aclk = ~aclk;

    // pruned and renormalised weights for one vertex under the current registers
    function automatic vertex_res_t prune_vertex(logic [NB-1:0][FIELD_W-1:0] w);
        vertex_res_t r;
        logic [NB-1:0] cand;
        logic [NB-1:0] keep;
        logic [31:0]   total;
        logic [31:0]   q;
        int            rank;
        r = '0;
        total = 0;
        for (int i = 0; i < NB; i++) cand[i] = w[i] > cur_min_weight;
        for (int i = 0; i < NB; i++) begin
            keep[i] = 1'b0;
            if (cand[i]) begin
                rank = 0;
                for (int j = 0; j < NB; j++)
                    if (j != i && cand[j] && (w[j] > w[i] || (w[j] == w[i] && j < i)))
                        rank++;
                if (rank < cur_max_bones) begin
                    keep[i] = 1'b1;
                    total += w[i];
                    r.kept = r.kept + 1'b1;
                end
            end
        end
        for (int i = 0; i < NB; i++)
            if (keep[i] && total != 0) begin
                q = (32'(w[i]) * 32'(FULL)) / total;
                r.pruned[i] = q[FIELD_W-1:0];
            end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= APB_AW'(idx) << 2; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_MAX_BONES) cur_max_bones = val[MAXB_W-1:0];
        else cur_min_weight = val[FIELD_W-1:0];
    endtask

    // one vertex transfer, with a random gap ahead of it; tvalid stays up afterwards
    task automatic send_vertex(input logic [NB-1:0][FIELD_W-1:0] w);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q = {expected_q, prune_vertex(w)};
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [FIELD_W-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FULL;
            2: return FIELD_W'($urandom_range(0, 15));
            3: return cur_min_weight + FIELD_W'($urandom_range(0, 2)) - 1'b1;
            4: return FIELD_W'($urandom_range(0, 7)) << 12;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // result side: random wait ahead of each transfer, in-order compare
    initial begin
        vertex_res_t got;
        vertex_res_t want;
        int          idle;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            idle = $urandom_range(0, 4);
            if (idle > 0) begin
                m_tready <= 1'b0;
                repeat (idle) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = m_tdata[NB*FIELD_W+CNT_W-1:0];
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_q.pop_front();
                for (int i = 0; i < NB; i++)
                    if (got.pruned[i] !== want.pruned[i])
                        report_mismatch($sformatf("pruned_%0d", i),
                                        got.pruned[i], want.pruned[i]);
                if (got.kept !== want.kept)
                    report_mismatch("kept_count", got.kept, want.kept);
            end
        end
    end

    task automatic test_reset_defaults();
        send_vertex({16'd7, 16'd6, 16'd0, FULL, FULL, 16'd1000, 16'd5, 16'd7});
        send_vertex('0);
        send_vertex({NB{FULL}});
        send_vertex({NB{16'h8000}});
        drain();
    endtask

    task automatic test_directed();
        write_reg(REG_MAX_BONES, 32'd8);
        write_reg(REG_MIN_WEIGHT, 32'd0);
        send_vertex({16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
        send_vertex({16'd1, 16'd2, 16'd4, 16'd8, 16'd16, 16'd32, 16'd64, FULL});
        send_vertex({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                     16'hAAAA, 16'h5555});
        drain();
        write_reg(REG_MAX_BONES, 32'd1);
        send_vertex({NB{16'd300}});
        send_vertex({16'd9, 16'd10, 16'd10, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0});
        drain();
        write_reg(REG_MAX_BONES, 32'd0);
        send_vertex({NB{FULL}});
        drain();
        write_reg(REG_MAX_BONES, 32'd15);
        write_reg(REG_MIN_WEIGHT, 32'hFFFF);
        send_vertex({NB{FULL}});
        drain();
        write_reg(REG_MIN_WEIGHT, 32'hFFFE);
        send_vertex({FULL, 16'hFFFE, FULL, 16'd0, FULL, 16'hFFFE, FULL, 16'd1});
        drain();
    endtask

    task automatic test_random_phase(input int n, input int maxb, input int minw);
        logic [NB-1:0][FIELD_W-1:0] w;
        write_reg(REG_MAX_BONES, maxb);
        write_reg(REG_MIN_WEIGHT, minw);
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < NB; i++) w[i] = rand_weight();
            send_vertex(w);
            // hold the sender until every result is back
            if (k == n / 2) drain();
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_random_phase(300, 8, 0);
        test_random_phase(250, 1, 100);
        test_random_phase(250, 3, 6);
        test_random_phase(250, 15, 40000);
        test_random_phase(250, 0, 10);
        for (int p = 0; p < 4; p++)
            test_random_phase(60, $urandom_range(1, 8), $urandom_range(0, 65535));
        if (errors == 0) $display("top_k_weight_prune_normalize_core regression: pass");
        else $display("top_k_weight_prune_normalize_core regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("top_k_weight_prune_normalize_core regression: fail");
        $finish;
    end
endmodule
